// File: hdl/dsf_pkg.sv
// dsf_pkg: shared constants and types for the duplicate signature filter
// no dependencies; used by duplicate_signature_filter

package dsf_pkg;

    // default number of stored signatures
    localparam int CAPACITY_DEF = 1024;

    // field widths
    localparam int HALF_W = 32;
    localparam int SIG_W  = 2 * HALF_W;
    localparam int PID_W  = 32;
    localparam int TS_W   = 64;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } dsf_state_t;

endpackage

// File: hdl/dsf_ram.sv
// dsf_ram: generic single-clock ram, one write and one read port, registered read
// no dependencies

module dsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/duplicate_signature_filter.sv
// duplicate_signature_filter: an empty store skips the scan and goes straight to finish;
// one read per cycle of the signature ram sets the scan length,
// a hit stops the scan early. one request is in work at a time, a finished result may wait
// in the output register while the next request is taken.
// reset clears the fill count and all control state; the signature ram is not cleared,
// only entries below the fill count are ever read.
// depends on dsf_pkg and dsf_ram

module duplicate_signature_filter #(
    parameter int CAPACITY = dsf_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dsf_pkg::HALF_W-1:0] instr_pointer_low,
    input  logic [dsf_pkg::HALF_W-1:0] stack_pointer_low,
    input  logic [dsf_pkg::PID_W-1:0]  process_id,
    input  logic [dsf_pkg::TS_W-1:0]   timestamp_ns,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       is_duplicate,
    output logic [dsf_pkg::SIG_W-1:0]  signature_out,
    output logic [dsf_pkg::PID_W-1:0]  process_id_out,
    output logic [dsf_pkg::TS_W-1:0]   timestamp_out,
    output logic                       store_full
);

    // ram address width and fill count width (count must reach CAPACITY itself)
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    dsf_pkg::dsf_state_t state_reg, state_next;

    // request held while it is worked on
    logic [dsf_pkg::SIG_W-1:0] sig_reg;
    logic [dsf_pkg::PID_W-1:0] pid_reg;
    logic [dsf_pkg::TS_W-1:0]  ts_reg;

    // scan control
    logic [CW-1:0] issue_idx_reg, issue_idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          match_reg, match_next;

    // fill count of the store
    logic [CW-1:0] used_reg, used_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic                      dup_out_reg;
    logic                      full_out_reg;
    logic [dsf_pkg::SIG_W-1:0] sig_out_reg;
    logic [dsf_pkg::PID_W-1:0] pid_out_reg;
    logic [dsf_pkg::TS_W-1:0]  ts_out_reg;

    // ram ports
    logic                      rd_en;
    logic [dsf_pkg::SIG_W-1:0] rd_data;
    logic                      wr_en;

    // handshake helpers
    logic in_accept;
    logic out_accept;
    logic out_free;
    logic load_out;
    logic hit;
    logic at_capacity;

    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid_reg && !out_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign at_capacity = (used_reg == CW'(CAPACITY));

    // compare the entry read in the previous cycle
    assign hit = cmp_valid_reg && (rd_data == sig_reg);

    // one read per cycle while entries below the fill count remain
    assign rd_en = (state_reg == dsf_pkg::ST_SCAN) && (issue_idx_reg < used_reg);

    // result leaves for the output register in finish once the slot is free
    assign load_out = (state_reg == dsf_pkg::ST_FINISH) && out_free;

    // a new signature is recorded only when not seen and room is left
    assign wr_en = load_out && !match_reg && !at_capacity;

    dsf_ram #(
        .WIDTH (dsf_pkg::SIG_W),
        .DEPTH (CAPACITY)
    ) u_sig_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (used_reg[AW-1:0]),
        .wr_data (sig_reg),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // controller: next state and scan bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = rd_en;
        match_next     = match_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        in_stall       = (state_reg != dsf_pkg::ST_IDLE);

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dsf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    issue_idx_next = '0;
                    match_next     = 1'b0;
                    // empty store: nothing to search
                    if (used_reg == '0)
                    begin
                        state_next = dsf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = dsf_pkg::ST_SCAN;
                    end
                end
            end
            dsf_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    match_next = 1'b1;
                    state_next = dsf_pkg::ST_FINISH;
                end
                else if (issue_idx_reg == used_reg)
                begin
                    // last entry compared, no match
                    state_next = dsf_pkg::ST_FINISH;
                end
            end
            dsf_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = dsf_pkg::ST_IDLE;
                    if (wr_en)
                    begin
                        used_next = used_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = dsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsf_pkg::ST_IDLE;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            match_reg     <= match_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sig_reg <= {instr_pointer_low, stack_pointer_low};
            pid_reg <= process_id;
            ts_reg  <= timestamp_ns;
        end
        if (load_out)
        begin
            dup_out_reg  <= match_reg;
            full_out_reg <= !match_reg && at_capacity;
            sig_out_reg  <= sig_reg;
            pid_out_reg  <= pid_reg;
            ts_out_reg   <= ts_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_duplicate   = dup_out_reg;
    assign signature_out  = sig_out_reg;
    assign process_id_out = pid_out_reg;
    assign timestamp_out  = ts_out_reg;
    assign store_full     = full_out_reg;

    // fill count never passes the capacity
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // reads stay below the fill count, never touching unwritten entries
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_idx_reg < used_reg))
        else $error("read beyond written entries");

    // a duplicate never reports a full store
    a_dup_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(dup_out_reg && full_out_reg))
        else $error("duplicate and full flagged together");

    // fill count moves only by one, and only when a result is loaded
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            (used_reg == $past(used_reg) + CW'(1)) && $past(load_out))
        else $error("fill count changed unexpectedly");

    // a request is only taken from idle and starts a search or finishes at once
    a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == dsf_pkg::ST_SCAN) || (state_reg == dsf_pkg::ST_FINISH))
        else $error("request not followed by search");

endmodule
